// ===== rtl/mscc_pkg.sv =====
// ----------------------------------------------------------------------------
// mscc_pkg
// Shared types, opcode and function codes, and memory sizing for the core.
// ----------------------------------------------------------------------------
package mscc_pkg;

    // Data memory size in words; the index width and byte span follow from it.
    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int MEM_BYTES = 4 * MEM_WORDS;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // Function codes of the special opcode
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    // Service codes found in v0 at a syscall
    localparam logic [31:0] SVC_PRINT_INT = 32'd1;
    localparam logic [31:0] SVC_PRINT_STR = 32'd4;
    localparam logic [31:0] SVC_EXIT      = 32'd10;

    // Registers that a syscall reads
    localparam logic [4:0] REG_V0 = 5'd2;
    localparam logic [4:0] REG_A0 = 5'd4;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_PRINT_INT = 3'd1,
        KIND_PRINT_STR = 3'd2,
        KIND_EXIT      = 3'd3,
        KIND_OTHER     = 3'd4
    } syscall_kind_t;

    // Everything the execute step produces for one instruction.
    typedef struct packed {
        logic                reg_write;
        logic [4:0]          dest_reg;
        logic [31:0]         write_value;
        logic [31:0]         alu_value;
        logic                mem_fault;
        logic                store_done;
        syscall_kind_t       syscall_kind;
        logic [31:0]         syscall_arg;
        logic                string_addr_bad;
        logic                halted;
        logic                load_ok;
        logic                exit_req;
        logic [MEM_AW-1:0]   mem_idx;
    } exec_t;

endpackage

// ===== rtl/mscc_instr_if.sv =====
// ----------------------------------------------------------------------------
// mscc_instr_if
// Request channel carrying one instruction word per handshake.
// ----------------------------------------------------------------------------
interface mscc_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

// ===== rtl/mscc_result_if.sv =====
// ----------------------------------------------------------------------------
// mscc_result_if
// Result channel carrying the outcome of one executed instruction.
// ----------------------------------------------------------------------------
interface mscc_result_if;
    logic        valid;
    logic        ready;
    logic        reg_write;
    logic [4:0]  dest_reg;
    logic [31:0] write_value;
    logic [31:0] alu_value;
    logic        mem_fault;
    logic        store_done;
    logic [2:0]  syscall_kind;
    logic [31:0] syscall_arg;
    logic        string_addr_bad;
    logic        halted;

    modport source (
        output valid, output reg_write, output dest_reg, output write_value,
        output alu_value, output mem_fault, output store_done, output syscall_kind,
        output syscall_arg, output string_addr_bad, output halted,
        input ready
    );
    modport sink (
        input valid, input reg_write, input dest_reg, input write_value,
        input alu_value, input mem_fault, input store_done, input syscall_kind,
        input syscall_arg, input string_addr_bad, input halted,
        output ready
    );
endinterface

// ===== rtl/mscc_exec.sv =====
// ----------------------------------------------------------------------------
// mscc_exec
// Decode and execute one instruction from its word and its two operands.
// ----------------------------------------------------------------------------
module mscc_exec (
    input  logic [31:0]    instruction,
    input  logic [31:0]    op_a,
    input  logic [31:0]    op_b,
    input  logic           halted_in,
    output mscc_pkg::exec_t ex
);
    import mscc_pkg::*;

    logic [5:0]  opc;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sh;
    logic [31:0] imm;
    logic [31:0] addr;
    logic        fault;

    assign opc   = instruction[31:26];
    assign fn    = instruction[5:0];
    assign rt    = instruction[20:16];
    assign rd    = instruction[15:11];
    assign sh    = instruction[10:6];
    assign imm   = {{16{instruction[15]}}, instruction[15:0]};
    assign addr  = op_a + imm;
    assign fault = addr[31:2] >= 30'(MEM_WORDS);

    always_comb
    begin
        ex          = '0;
        ex.dest_reg = rt;
        ex.mem_idx  = addr[MEM_AW+1:2];
        if (halted_in)
        begin
            ex.dest_reg = '0;
            ex.halted   = 1'b1;
        end
        else if (opc == OP_SPECIAL && fn == FN_SYSCALL)
        begin
            // op_a holds v0 and op_b holds a0 for a syscall
            ex.dest_reg    = '0;
            ex.syscall_arg = op_b;
            case (op_a)
                SVC_PRINT_INT: ex.syscall_kind = KIND_PRINT_INT;
                SVC_PRINT_STR:
                begin
                    ex.syscall_kind    = KIND_PRINT_STR;
                    ex.string_addr_bad = op_b >= 32'(MEM_BYTES);
                end
                SVC_EXIT:
                begin
                    ex.syscall_kind = KIND_EXIT;
                    ex.exit_req     = 1'b1;
                end
                default: ex.syscall_kind = KIND_OTHER;
            endcase
        end
        else if (opc == OP_SPECIAL)
        begin
            ex.dest_reg  = rd;
            ex.reg_write = 1'b1;
            case (fn)
                FN_ADD:  ex.alu_value = op_a + op_b;
                FN_SUB:  ex.alu_value = op_a - op_b;
                FN_AND:  ex.alu_value = op_a & op_b;
                FN_OR:   ex.alu_value = op_a | op_b;
                FN_SLT:  ex.alu_value = {31'd0, $signed(op_a) < $signed(op_b)};
                FN_SLL:  ex.alu_value = op_b << sh;
                FN_MULT: ex.alu_value = op_a * op_b;
                default: ex.alu_value = '0;
            endcase
            ex.write_value = ex.alu_value;
        end
        else if (opc == OP_ADDI)
        begin
            ex.alu_value   = addr;
            ex.write_value = addr;
            ex.reg_write   = 1'b1;
        end
        else if (opc == OP_SLTI)
        begin
            ex.alu_value   = {31'd0, $signed(op_a) < $signed(imm)};
            ex.write_value = ex.alu_value;
            ex.reg_write   = 1'b1;
        end
        else if (opc == OP_LUI)
        begin
            ex.alu_value   = {instruction[15:0], 16'd0};
            ex.write_value = ex.alu_value;
            ex.reg_write   = 1'b1;
        end
        else if (opc inside {OP_LW, OP_SW})
        begin
            ex.alu_value = addr;
            ex.mem_fault = fault;
            if (opc == OP_LW)
            begin
                // loaded word replaces write_value later; a faulting load writes zero
                ex.reg_write = 1'b1;
                ex.load_ok   = !fault;
            end
            else
            begin
                ex.store_done = !fault;
            end
        end

        // register 0 takes no write
        ex.reg_write = ex.reg_write && (ex.dest_reg != 5'd0);
    end

endmodule

// ===== rtl/mips_subset_single_cycle_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core
// Small MIPS32 integer core: register file, data memory and one result per
// instruction word, executed between an operand register and a result register.
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                         handshake
//  -------   ---------  ------------------------------  -----------
//  instr     in         instruction[31:0]               valid/ready
//  result    out        reg_write .. halted (10 fields)  valid/ready
//
// One instruction per clock sustained while the result is taken; the
// register file is read into the operand register as a request is
// accepted, then execute runs into the result register (the data memory
// read for lw lands alongside it).
// After reset the data memory is cleared one word a cycle, and no request
// is accepted meanwhile.
// A stalled result freezes the whole pipeline; requests are taken again as
// soon as the result register drains or is empty.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core (
    input  logic clk,
    input  logic rst_n,
    mscc_instr_if.sink    instr,
    mscc_result_if.source result
);
    import mscc_pkg::*;

    // Pipeline advance: the result register is empty or is being taken.
    logic adv;
    logic accept;

    // Clearing pass over the data memory
    logic              clearing_reg;
    logic [MEM_AW-1:0] clr_idx_reg;

    // Register file: memory with two registered read ports, valid bits for reset
    logic [31:0] rf_mem [32];
    logic [31:0] rf_valid_reg;
    logic [31:0] rd_a_raw_reg;
    logic [31:0] rd_b_raw_reg;
    logic        a_ok_reg;
    logic        b_ok_reg;
    logic        a_byp_reg;
    logic        b_byp_reg;
    logic [31:0] byp_val_reg;
    logic [4:0]  ra_in;
    logic [4:0]  rb_in;
    logic        sys_in;

    // Execute stage
    logic        s1_valid_reg;
    logic [31:0] s1_instr_reg;
    logic [4:0]  s1_ra_reg;
    logic [4:0]  s1_rb_reg;
    logic [31:0] read_a;
    logic [31:0] read_b;
    logic [31:0] op_a;
    logic [31:0] op_b;
    exec_t       ex;
    logic        exit_seen_reg;

    // Data memory
    logic [31:0] dmem [MEM_WORDS];
    logic [31:0] mem_rdata_reg;
    logic        dmem_we;

    // Result stage
    logic        s2_valid_reg;
    exec_t       s2_reg;
    logic [31:0] wb_val;
    logic        rf_we;

    assign adv    = !s2_valid_reg || result.ready;
    assign accept = instr.valid && instr.ready;
    assign instr.ready = adv && !clearing_reg;

    // A syscall reads v0 and a0 through the two ports in place of rs and rt.
    assign sys_in = (instr.instruction[31:26] == OP_SPECIAL)
                 && (instr.instruction[5:0] == FN_SYSCALL);
    assign ra_in  = sys_in ? REG_V0 : instr.instruction[25:21];
    assign rb_in  = sys_in ? REG_A0 : instr.instruction[20:16];

    // Write-back value of the item in the result register
    assign wb_val = s2_reg.load_ok ? mem_rdata_reg : s2_reg.write_value;
    // Write back as the result leaves, once per item
    assign rf_we  = adv && s2_valid_reg && s2_reg.reg_write;

    // ------------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[s2_reg.dest_reg] <= wb_val;
        end
        if (adv)
        begin
            rd_a_raw_reg <= rf_mem[ra_in];
            rd_b_raw_reg <= rf_mem[rb_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_valid_reg <= '0;
            a_ok_reg     <= 1'b0;
            b_ok_reg     <= 1'b0;
            a_byp_reg    <= 1'b0;
            b_byp_reg    <= 1'b0;
        end
        else
        begin
            if (rf_we)
            begin
                rf_valid_reg[s2_reg.dest_reg] <= 1'b1;
            end
            if (adv)
            begin
                // Capture the write landing on this same edge (read sees old data).
                a_ok_reg  <= rf_valid_reg[ra_in];
                b_ok_reg  <= rf_valid_reg[rb_in];
                a_byp_reg <= rf_we && (s2_reg.dest_reg == ra_in);
                b_byp_reg <= rf_we && (s2_reg.dest_reg == rb_in);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            byp_val_reg <= wb_val;
        end
    end

    assign read_a = a_byp_reg ? byp_val_reg : (a_ok_reg ? rd_a_raw_reg : 32'd0);
    assign read_b = b_byp_reg ? byp_val_reg : (b_ok_reg ? rd_b_raw_reg : 32'd0);

    // Forward the older item still in the result register; it writes back later.
    assign op_a = (s2_valid_reg && s2_reg.reg_write && s2_reg.dest_reg == s1_ra_reg)
                ? wb_val : read_a;
    assign op_b = (s2_valid_reg && s2_reg.reg_write && s2_reg.dest_reg == s1_rb_reg)
                ? wb_val : read_b;

    // ------------------------------------------------------------------------
    // Execute stage
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            exit_seen_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg && ex.exit_req)
            begin
                exit_seen_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_instr_reg <= instr.instruction;
            s1_ra_reg    <= ra_in;
            s1_rb_reg    <= rb_in;
        end
    end

    mscc_exec u_exec (
        .instruction (s1_instr_reg),
        .op_a        (op_a),
        .op_b        (op_b),
        .halted_in   (exit_seen_reg),
        .ex          (ex)
    );

    // ------------------------------------------------------------------------
    // Data memory and its clearing pass
    // ------------------------------------------------------------------------
    assign dmem_we = adv && s1_valid_reg && ex.store_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == MEM_AW'(MEM_WORDS - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            dmem[clr_idx_reg] <= '0;
        end
        else if (dmem_we)
        begin
            dmem[ex.mem_idx] <= op_b;
        end
        if (adv)
        begin
            mem_rdata_reg <= dmem[ex.mem_idx];
        end
    end

    // ------------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_reg <= ex;
        end
    end

    assign result.valid           = s2_valid_reg;
    assign result.reg_write       = s2_reg.reg_write;
    assign result.dest_reg        = s2_reg.dest_reg;
    assign result.write_value     = wb_val;
    assign result.alu_value       = s2_reg.alu_value;
    assign result.mem_fault       = s2_reg.mem_fault;
    assign result.store_done      = s2_reg.store_done;
    assign result.syscall_kind    = s2_reg.syscall_kind;
    assign result.syscall_arg     = s2_reg.syscall_arg;
    assign result.string_addr_bad = s2_reg.string_addr_bad;
    assign result.halted          = s2_reg.halted;

`ifndef SYNTHESIS
    // A halted item leaves no trace in state or in the syscall fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.halted) |->
            (!result.reg_write && !result.store_done && result.syscall_kind == KIND_NONE))
        else $error("halted result carries side effects");

    // Register 0 is never written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (s2_reg.dest_reg != 5'd0))
        else $error("write back to register 0");

    // The pipeline stays empty while the data memory is being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> (!s1_valid_reg && !s2_valid_reg && !dmem_we))
        else $error("item in flight during memory clear");

    // A completed store never faults.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.store_done) |-> !result.mem_fault)
        else $error("store reported both done and fault");
`endif

endmodule
